[rtl/aes_pkg.sv]
// ----------------------------------------------------------------------------
// aes_pkg: shared types, constants and round functions of the AES cipher
// Holds the S-box, the GF(2^8) helpers, the round transforms and the
// register indices of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

  localparam int unsigned BlockW   = 128;
  localparam int unsigned HalfW    = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NrMax    = 14;
  localparam int unsigned Nr128    = 10;
  localparam int unsigned NumRk    = NrMax + 1;

  localparam logic [CfgIdxW-1:0] RegMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey0 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey1 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey2 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKey3 = 3'd4;

  typedef logic [BlockW-1:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    gf_double = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte i of the state sits at bits 127-8i.
  function automatic logic [7:0] st_byte(input block_t s, input int unsigned i);
    st_byte = s[BlockW-1-8*i -: 8];
  endfunction

  // One full round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
  function automatic block_t aes_round(input block_t s, input block_t rk, input logic last);
    block_t t;
    block_t m;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[BlockW-1-8*(i+4*c) -: 8] = SBOX[st_byte(s, i + 4*((c+i) % 4))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = st_byte(t, 4*c);
      a1 = st_byte(t, 4*c+1);
      a2 = st_byte(t, 4*c+2);
      a3 = st_byte(t, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      m[BlockW-1-32*c -: 32] = {a0 ^ al ^ gf_double(a0 ^ a1), a1 ^ al ^ gf_double(a1 ^ a2),
                                a2 ^ al ^ gf_double(a2 ^ a3), a3 ^ al ^ gf_double(a3 ^ a0)};
    end
    aes_round = (last ? t : m) ^ rk;
  endfunction

endpackage
`default_nettype wire

[rtl/aes_stream_if.sv]
// ----------------------------------------------------------------------------
// aes_stream_if: valid/ready channels of the AES block
// Data channel carrying two 64-bit halves and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface aes_stream_if;
  logic                       valid;
  logic                       ready;
  logic [aes_pkg::HalfW-1:0]  high;
  logic [aes_pkg::HalfW-1:0]  low;
  modport source (output valid, output high, output low, input ready);
  modport sink   (input valid, input high, input low, output ready);
endinterface

interface aes_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [aes_pkg::CfgIdxW-1:0]  index;
  logic [aes_pkg::HalfW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/aes_keysched.sv]
// ----------------------------------------------------------------------------
// aes_keysched: round-key expansion after a key write
// Walks the key schedule one 32-bit word a cycle into a round-key register
// bank. Busy flags the walk; the bank is only valid once busy falls.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_keysched (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 mode_i,
  input  wire logic [255:0]         key_i,
  output logic                      busy_o,
  output aes_pkg::block_t           rk_o [aes_pkg::NumRk]
);
  // word counter covers 60 schedule words
  logic [5:0]  idx_q, idx_d;
  logic        busy_q, busy_d;
  logic        mode_q;
  logic [7:0]  rc_q, rc_d;
  logic [31:0] w_q [8];
  logic [31:0] w_new, t;
  logic [5:0]  total;
  logic [2:0]  pos;

  assign total = mode_q ? 6'd60 : 6'd44;
  assign pos   = mode_q ? idx_q[2:0] : {1'b0, idx_q[1:0]};

  // next schedule word from the sliding window of the last nk words
  always_comb begin
    t = mode_q ? w_q[7] : w_q[3];
    if (pos == 3'd0) begin
      t = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_q, 24'h0};
    end else if (mode_q && pos == 3'd4) begin
      t = aes_pkg::sub_word(t);
    end
    w_new = w_q[0] ^ t;
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    rc_d   = rc_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = mode_i ? 6'd8 : 6'd4;
      rc_d   = 8'h01;
    end else if (busy_q) begin
      idx_d = idx_q + 6'd1;
      if (pos == 3'd0) rc_d = aes_pkg::gf_double(rc_q);
      if (idx_q == total - 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 6'd0;
      rc_q   <= 8'h01;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      rc_q   <= rc_d;
    end
  end

  // window shift and round-key bank write
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      for (int i = 0; i < 8; i++) w_q[i] <= key_i[255-32*i -: 32];
      rk_o[0] <= key_i[255:128];
      rk_o[1] <= key_i[127:0];
    end else if (busy_q) begin
      for (int i = 0; i < 7; i++) w_q[i] <= (!mode_q && i == 3) ? w_new : w_q[i+1];
      w_q[7] <= w_new;
      rk_o[idx_q[5:2]][127-32*idx_q[1:0] -: 32] <= w_new;
    end
  end

  assign busy_o = busy_q;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q)
    else $error("schedule walk did not start");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> idx_q < 6'd60)
    else $error("schedule index out of range");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && idx_q == total - 6'd1) |=> !busy_q)
    else $error("schedule walk overran");
`endif
endmodule
`default_nettype wire

[rtl/aes_block_encrypt_128_256.sv]
// ----------------------------------------------------------------------------
// aes_block_encrypt_128_256: pipelined AES-128/AES-256 block encryption
// Key addition then one round per stage; one block per cycle when not stalled.
// ----------------------------------------------------------------------------
// A block enters every cycle while the output is taken and no register write
// or key expansion is under way. It sits in 15 stage registers (one for the
// initial key addition, one per round up to 14; AES-128 blocks pass the last
// four stages unchanged) and the last stage drives the output directly. A
// result not taken holds the whole pipeline, so the input ready follows the
// output ready combinationally. After any key or mode write the round keys
// are re-expanded: a registered start, then one schedule word a cycle. No
// block is accepted in the write cycle, the start cycle or during the walk.
`default_nettype none
module aes_block_encrypt_128_256 (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  aes_cfg_if.sink       cfg_i,
  aes_stream_if.sink    in_i,
  aes_stream_if.source  out_o
);
  localparam int unsigned Ns = aes_pkg::NumRk;

  logic        mode_q;
  logic [63:0] key_q [4];
  logic        cfg_wr, pend_q, busy;
  aes_pkg::block_t rk [Ns];

  logic            v_q [Ns];
  aes_pkg::block_t s_q [Ns];
  logic            m_q [Ns];
  logic            adv;

  // configuration registers; a write queues a re-expansion
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      pend_q <= 1'b1;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_i.index)
          aes_pkg::RegMode: mode_q   <= cfg_i.data[0];
          aes_pkg::RegKey0: key_q[0] <= cfg_i.data;
          aes_pkg::RegKey1: key_q[1] <= cfg_i.data;
          aes_pkg::RegKey2: key_q[2] <= cfg_i.data;
          aes_pkg::RegKey3: key_q[3] <= cfg_i.data;
          default: ;
        endcase
      end
      pend_q <= cfg_wr;
    end
  end

  aes_keysched u_ks (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pend_q),
    .mode_i  (mode_q),
    .key_i   ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .busy_o  (busy),
    .rk_o    (rk)
  );

  // pipeline advances unless the last stage holds a result not taken
  assign adv        = !v_q[Ns-1] || out_o.ready;
  assign in_i.ready = adv && !busy && !pend_q && !cfg_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Ns; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_i.valid && in_i.ready;
      for (int i = 1; i < Ns; i++) v_q[i] <= v_q[i-1];
    end
  end

  // stage 0 whitening, stage r is round r; short-key blocks pass stages 11+
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0] <= {in_i.high, in_i.low} ^ rk[0];
      m_q[0] <= mode_q;
      for (int r = 1; r < Ns; r++) begin
        m_q[r] <= m_q[r-1];
        if (!m_q[r-1] && r > aes_pkg::Nr128) begin
          s_q[r] <= s_q[r-1];
        end else begin
          s_q[r] <= aes_pkg::aes_round(s_q[r-1], rk[r],
                      (r == aes_pkg::NrMax) || (!m_q[r-1] && r == aes_pkg::Nr128));
        end
      end
    end
  end

  assign out_o.valid = v_q[Ns-1];
  assign out_o.high  = s_q[Ns-1][127:64];
  assign out_o.low   = s_q[Ns-1][63:0];

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_i.ready) else $error("block accepted during key expansion");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.high)))
    else $error("stalled result changed");
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |-> !in_i.ready) else $error("block accepted during register write");
`endif
endmodule
`default_nettype wire
